// ===== rtl/core/aes128p_pkg.sv =====
// Package: AES state type, S-boxes and round functions for the padded AES-128 block.
`timescale 1ns / 1ps
package aes128p_pkg;

  typedef logic [0:15][7:0] state_t;
  typedef state_t [0:10] rkeys_t;

  typedef enum logic {
    CMD_SEAL = 1'b0,
    CMD_OPEN = 1'b1
  } cmd_t;

  localparam logic [3:0] MAX_MESSAGE_BYTES = 4'd15;
  localparam int         NUM_ROUNDS = 10;
  localparam logic [4:0] BLOCK_BYTES = 5'd16;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0, 8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0, 8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5, 8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c, 8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e, 8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38, 8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87, 8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d, 8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2, 8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16, 8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda, 8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a, 8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02, 8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea, 8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85, 8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89, 8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20, 8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31, 8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d, 8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0, 8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26, 8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  localparam logic [7:0] RCON [1:10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic state_t mix_cols(input state_t s);
    state_t o;
    logic [7:0] t;
    for (int c = 0; c < 16; c += 4) begin
      t = s[c] ^ s[c+1] ^ s[c+2] ^ s[c+3];
      o[c]   = s[c]   ^ t ^ xt(s[c]   ^ s[c+1]);
      o[c+1] = s[c+1] ^ t ^ xt(s[c+1] ^ s[c+2]);
      o[c+2] = s[c+2] ^ t ^ xt(s[c+2] ^ s[c+3]);
      o[c+3] = s[c+3] ^ t ^ xt(s[c+3] ^ s[c]);
    end
    return o;
  endfunction

  function automatic state_t inv_mix_cols(input state_t s);
    state_t o;
    logic [7:0] u;
    logic [7:0] v;
    for (int c = 0; c < 16; c += 4) begin
      u = xt(xt(s[c] ^ s[c+2]));
      v = xt(xt(s[c+1] ^ s[c+3]));
      o[c]   = s[c]   ^ u;
      o[c+1] = s[c+1] ^ v;
      o[c+2] = s[c+2] ^ u;
      o[c+3] = s[c+3] ^ v;
    end
    return mix_cols(o);
  endfunction

  // Forward round: shift rows, substitute, mix (unless last), add key.
  function automatic state_t fwd_round(input state_t s, input state_t k, input logic last);
    state_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r + 4*c] = SBOX[s[r + 4*((c + r) & 3)]];
      end
    end
    if (!last) begin
      t = mix_cols(t);
    end
    return t ^ k;
  endfunction

  // Inverse round: unshift, unsubstitute, add key, unmix (unless last).
  function automatic state_t inv_round(input state_t s, input state_t k, input logic last);
    state_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r + 4*((c + r) & 3)] = ISBOX[s[r + 4*c]];
      end
    end
    t = t ^ k;
    if (!last) begin
      t = inv_mix_cols(t);
    end
    return t;
  endfunction

  function automatic state_t next_key(input state_t k, input logic [7:0] rc);
    state_t o;
    logic [0:3][7:0] t;
    t[0] = SBOX[k[13]] ^ rc;
    t[1] = SBOX[k[14]];
    t[2] = SBOX[k[15]];
    t[3] = SBOX[k[12]];
    for (int j = 0; j < 4; j++) begin
      o[j]      = k[j]      ^ t[j];
      o[4 + j]  = k[4 + j]  ^ o[j];
      o[8 + j]  = k[8 + j]  ^ o[4 + j];
      o[12 + j] = k[12 + j] ^ o[8 + j];
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/aes128p_keysched.sv =====
// Key registers, APB register port and registered round-key chain.
`timescale 1ns / 1ps
module aes128p_keysched (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  output aes128p_pkg::rkeys_t    round_keys,
  output logic                   keys_settling
);

  logic [63:0] key_high_r;
  logic [63:0] key_low_r;
  logic [3:0]  settle_r;
  logic [3:0]  settle_nxt;
  aes128p_pkg::state_t rk_r [1:10];
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign prdata = paddr[3] ? key_low_r : key_high_r;

  always_comb begin
    settle_nxt = settle_r;
    if (wr_en) begin
      settle_nxt = 4'(aes128p_pkg::NUM_ROUNDS);
    end else if (settle_r != 4'd0) begin
      settle_nxt = settle_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      settle_r   <= 4'(aes128p_pkg::NUM_ROUNDS);
    end else begin
      settle_r <= settle_nxt;
      if (wr_en && !paddr[3]) begin
        key_high_r <= pwdata;
      end
      if (wr_en && paddr[3]) begin
        key_low_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rk_r[1] <= aes128p_pkg::next_key({key_high_r, key_low_r}, aes128p_pkg::RCON[1]);
    for (int i = 2; i <= 10; i++) begin
      rk_r[i] <= aes128p_pkg::next_key(rk_r[i-1], aes128p_pkg::RCON[i]);
    end
  end

  always_comb begin
    round_keys[0] = {key_high_r, key_low_r};
    for (int i = 1; i <= 10; i++) begin
      round_keys[i] = rk_r[i];
    end
  end

  assign keys_settling = (settle_r != 4'd0);

endmodule

// ===== rtl/core/aes128_padded_block_cipher.sv =====
// Top level: padded AES-128 seal/open pipeline with one round per stage.
`timescale 1ns / 1ps
// One word enters per cycle whenever busy is low. Its result passes through the pad/whiten stage,
// ten round stages and the unpad/format stage, and is then on the outputs with out_valid high.
// The round keys are a registered chain of ten key-expansion steps, so busy stays high after
// reset and after every key write while that chain reloads. Results cannot be stalled: they
// are valid for exactly one cycle.
module aes128_padded_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic [3:0]  in_message_bytes,
  input  logic [63:0] in_filler_high,
  input  logic [63:0] in_filler_low,
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  output logic [4:0]  out_length,
  output logic        out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  aes128p_pkg::rkeys_t rkeys;
  logic                settling;

  aes128p_keysched u_keys (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .round_keys    (rkeys),
    .keys_settling (settling)
  );

  assign busy = settling;

  // Pad and whiten
  aes128p_pkg::state_t blk;
  aes128p_pkg::state_t fil;
  aes128p_pkg::state_t padded;
  aes128p_pkg::state_t init;
  logic [3:0]          pad_cnt;
  logic                bad_len;
  logic                accept;

  assign accept  = start & ~busy;
  assign blk     = {in_block_high, in_block_low};
  assign fil     = {in_filler_high, in_filler_low};
  assign pad_cnt = 4'(~in_message_bytes + 4'd1);
  assign bad_len = (in_command == aes128p_pkg::CMD_SEAL) &&
                   ((in_message_bytes == 4'd0) ||
                    (in_message_bytes > aes128p_pkg::MAX_MESSAGE_BYTES));

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      padded[i] = (4'(i) < pad_cnt) ? fil[i] : blk[i];
    end
    padded[0] = {pad_cnt, fil[0][3:0]};
    if (in_command == aes128p_pkg::CMD_OPEN) begin
      init = blk ^ rkeys[0];
    end else begin
      init = padded ^ rkeys[10];
    end
  end

  // Round pipeline
  aes128p_pkg::state_t st_r  [0:10];
  logic                vld_r [0:10];
  logic                cmd_r [0:10];
  logic                bad_r [0:10];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= 10; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int j = 1; j <= 10; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r[0]  <= init;
    cmd_r[0] <= in_command;
    bad_r[0] <= bad_len;
    for (int j = 1; j <= 10; j++) begin
      cmd_r[j] <= cmd_r[j-1];
      bad_r[j] <= bad_r[j-1];
      if (cmd_r[j-1] == aes128p_pkg::CMD_OPEN) begin
        st_r[j] <= aes128p_pkg::fwd_round(st_r[j-1], rkeys[j], j == 10);
      end else begin
        st_r[j] <= aes128p_pkg::inv_round(st_r[j-1], rkeys[10-j], j == 10);
      end
    end
  end

  // Unpad and format
  aes128p_pkg::state_t fin;
  aes128p_pkg::state_t res_nxt;
  logic [4:0]          len_nxt;
  logic                status_nxt;
  logic [3:0]          opad;
  logic [4:0]          olen;

  assign fin  = st_r[10];
  assign opad = fin[0][7:4];
  assign olen = aes128p_pkg::BLOCK_BYTES - {1'b0, opad};

  always_comb begin
    res_nxt    = fin;
    len_nxt    = aes128p_pkg::BLOCK_BYTES;
    status_nxt = 1'b0;
    if (bad_r[10]) begin
      res_nxt    = '0;
      len_nxt    = 5'd0;
      status_nxt = 1'b1;
    end else if (cmd_r[10] == aes128p_pkg::CMD_OPEN) begin
      len_nxt = olen;
      for (int i = 0; i < 16; i++) begin
        res_nxt[i] = (5'(i) < olen) ? fin[4'(opad + 4'(i))] : 8'h00;
      end
    end
  end

  logic                out_valid_r;
  aes128p_pkg::state_t res_r;
  logic [4:0]          len_r;
  logic                status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[10];
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    len_r    <= len_nxt;
    status_r <= status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = res_r[0:7];
  assign out_result_low  = res_r[8:15];
  assign out_length      = len_r;
  assign out_status      = status_r;

endmodule
